[rtl/brf_pkg.sv]
`timescale 1ns / 1ps

package brf_pkg;

    localparam int LANES = 8;
    localparam int LANE_BITS = 3;
    localparam logic [3:0] MAX_BYTES = 4'd8;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_RDATA = 2'b10
    } state_t;

    // per-lane request: write or read, bytes to write starting at the base pointer
    typedef struct packed {
        logic       wr;
        logic       rd;
        logic [3:0] cnt;
    } lane_ctl_t;

endpackage

[rtl/byte_ring_fifo_multibyte.sv]
`timescale 1ns / 1ps
// Push and clear results are registered and appear in the cycle after acceptance; a pop result
// passes the bank read register and then the output register. One push or clear per cycle while
// the output is taken; no new request is taken while a pop is in S_RDATA, set by the registered
// read of the eight byte banks. DEPTH must be a multiple of 8. Reset clears both pointers, the
// byte count, the state and the output valid; the byte banks are not cleared.
module byte_ring_fifo_multibyte
    import brf_pkg::*;
#(
    parameter int DEPTH = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [3:0]  byte_count,
    input  logic [63:0] write_data,
    input  logic        allow_partial,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        status,
    output logic [3:0]  bytes_moved,
    output logic [63:0] read_data,
    output logic [10:0] fill_level
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    state_t               state_reg, state_next;
    logic [PW-1:0]        rp_reg, rp_next;
    logic [PW-1:0]        wp_reg, wp_next;
    logic [CW-1:0]        count_reg, count_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 status_reg, status_next;
    logic [3:0]           bytes_moved_reg, bytes_moved_next;
    logic [63:0]          read_data_reg;
    logic [10:0]          fill_level_reg;
    logic [LANE_BITS-1:0] rot_reg;

    logic                 accept;
    logic [3:0]           n_sat;
    logic [CW-1:0]        free_bytes;
    logic                 push_ok;
    logic                 pop_short;
    logic                 pop_ok;
    logic [3:0]           pop_n;
    logic [PW:0]          wp_sum;
    logic [PW:0]          rp_sum;
    lane_ctl_t            lane_ctl;
    logic [PW-1:0]        lane_base;
    logic [7:0]           lane_data [LANES];
    logic [63:0]          merged;

    assign in_ready = state_reg[0] && (!out_valid_reg || out_ready);
    assign accept = in_valid && in_ready;

    assign n_sat = (byte_count > MAX_BYTES) ? MAX_BYTES : byte_count;
    assign free_bytes = CW'(DEPTH) - count_reg;
    assign push_ok = CW'(n_sat) <= free_bytes;
    assign pop_short = count_reg < CW'(n_sat);
    assign pop_n = pop_short ? 4'(count_reg) : n_sat;
    assign pop_ok = !pop_short || allow_partial;

    assign wp_sum = {1'b0, wp_reg} + (PW+1)'(n_sat);
    assign rp_sum = {1'b0, rp_reg} + (PW+1)'(pop_n);

    always_comb
    begin
        lane_ctl.wr = accept && (opcode == OP_PUSH) && push_ok;
        lane_ctl.rd = accept && (opcode == OP_POP) && pop_ok;
        lane_ctl.cnt = n_sat;
        lane_base = (opcode == OP_POP) ? rp_reg : wp_reg;
    end

    generate
        for (genvar g = 0; g < LANES; g++)
        begin : g_lane
            brf_lane #(
                .DEPTH (DEPTH),
                .LANE  (g)
            ) u_lane (
                .clk        (clk),
                .ctl        (lane_ctl),
                .base       (lane_base),
                .write_data (write_data),
                .rdata      (lane_data[g])
            );
        end
    endgenerate

    brf_merge u_merge (
        .lane_data (lane_data),
        .rot       (rot_reg),
        .cnt       (bytes_moved_reg),
        .read_data (merged)
    );

    always_comb
    begin
        state_next = state_reg;
        rp_next = rp_reg;
        wp_next = wp_reg;
        count_next = count_reg;
        out_valid_next = out_valid_reg;
        status_next = status_reg;
        bytes_moved_next = bytes_moved_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next = 1'b0;
                    bytes_moved_next = 4'd0;
                    out_valid_next = 1'b1;
                    unique case (opcode)
                        OP_PUSH:
                        begin
                            if (push_ok)
                            begin
                                wp_next = (wp_sum >= (PW+1)'(DEPTH))
                                    ? PW'(wp_sum - (PW+1)'(DEPTH)) : wp_sum[PW-1:0];
                                count_next = count_reg + CW'(n_sat);
                                bytes_moved_next = n_sat;
                            end
                            else
                            begin
                                status_next = 1'b1;
                            end
                        end
                        OP_POP:
                        begin
                            out_valid_next = 1'b0;
                            state_next = S_RDATA;
                            if (pop_ok)
                            begin
                                rp_next = (rp_sum >= (PW+1)'(DEPTH))
                                    ? PW'(rp_sum - (PW+1)'(DEPTH)) : rp_sum[PW-1:0];
                                count_next = count_reg - CW'(pop_n);
                                bytes_moved_next = pop_n;
                            end
                            else
                            begin
                                status_next = 1'b1;
                            end
                        end
                        OP_CLEAR:
                        begin
                            rp_next = '0;
                            wp_next = '0;
                            count_next = '0;
                        end
                        default:
                        begin
                            status_next = 1'b1;
                        end
                    endcase
                end
                else if (out_ready)
                begin
                    out_valid_next = 1'b0;
                end
            end
            S_RDATA:
            begin
                out_valid_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rp_reg <= '0;
            wp_reg <= '0;
            count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rp_reg <= rp_next;
            wp_reg <= wp_next;
            count_reg <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        bytes_moved_reg <= bytes_moved_next;
        if (accept)
        begin
            fill_level_reg <= 11'(count_next);
            rot_reg <= rp_reg[LANE_BITS-1:0];
            read_data_reg <= 64'd0;
        end
        else if (state_reg == S_RDATA)
        begin
            read_data_reg <= merged;
        end
    end

    assign out_valid = out_valid_reg;
    assign status = status_reg;
    assign bytes_moved = bytes_moved_reg;
    assign read_data = read_data_reg;
    assign fill_level = fill_level_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("stored count above depth");

    a_pop_to_rdata: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (opcode == OP_POP) |=> (state_reg == S_RDATA) && !out_valid_reg)
        else $error("pop request did not enter read state");

    a_rdata_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RDATA) |=> out_valid_reg && (state_reg == S_IDLE))
        else $error("pop result not presented");

    a_refused_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg |-> (bytes_moved_reg == 4'd0) && (read_data_reg == 64'd0))
        else $error("refused request moved data");

    a_moved_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> bytes_moved_reg <= MAX_BYTES)
        else $error("bytes moved above eight");

endmodule

[rtl/brf_lane.sv]
`timescale 1ns / 1ps

module brf_lane
    import brf_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int LANE = 0
)
(
    input  logic                         clk,
    input  lane_ctl_t                    ctl,
    input  logic [$clog2(DEPTH)-1:0]     base,
    input  logic [63:0]                  write_data,
    output logic [7:0]                   rdata
);

    localparam int PW = $clog2(DEPTH);
    localparam int ROWS = DEPTH / LANES;
    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [LANE_BITS-1:0] LANE_IDX = LANE_BITS'(LANE);

    logic [7:0]              mem [ROWS];
    logic [7:0]              rdata_reg;
    logic [LANE_BITS-1:0]    off;
    logic                    active;
    logic [PW:0]             addr_sum;
    logic [PW-1:0]           addr;
    logic [RW-1:0]           row;

    // byte index within the request that lands in this bank
    assign off = LANE_IDX - base[LANE_BITS-1:0];
    assign active = {1'b0, off} < ctl.cnt;
    assign addr_sum = {1'b0, base} + (PW+1)'(off);

    always_comb
    begin
        if (addr_sum >= (PW+1)'(DEPTH))
        begin
            addr = PW'(addr_sum - (PW+1)'(DEPTH));
        end
        else
        begin
            addr = addr_sum[PW-1:0];
        end
    end

    assign row = RW'(addr >> LANE_BITS);

    always_ff @(posedge clk)
    begin
        if (ctl.wr && active)
        begin
            mem[row] <= write_data[8*off +: 8];
        end
        if (ctl.rd)
        begin
            rdata_reg <= mem[row];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/brf_merge.sv]
`timescale 1ns / 1ps

module brf_merge
    import brf_pkg::*;
(
    input  logic [7:0]           lane_data [LANES],
    input  logic [LANE_BITS-1:0] rot,
    input  logic [3:0]           cnt,
    output logic [63:0]          read_data
);

    // byte i of the result comes from bank (rot + i) mod 8; bytes at or above cnt are zero
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            if (4'(i) < cnt)
            begin
                read_data[8*i +: 8] = lane_data[LANE_BITS'(rot + LANE_BITS'(i))];
            end
            else
            begin
                read_data[8*i +: 8] = 8'd0;
            end
        end
    end

endmodule
